// ----- src/omni3_pkg.sv -----
// Package: constants and types used by the omni3 wheel mixer core.
`default_nettype none
package omni3_pkg;

  // 0.866 in unsigned Q0.16
  localparam logic [16:0] Cos30Q16 = 17'd56754;

  // Numerator width (signed) and magnitude width
  localparam int NumW  = 43;
  localparam int MagW  = 42;
  localparam int QW    = 16;
  localparam int DivSteps = 16;
  // Stage count: products, sums, normalizer, divider steps, duty
  localparam int NumStages = 3 + DivSteps + 1;

  // Register addresses (word index)
  localparam logic [1:0] RegLength = 2'd0;
  localparam logic [1:0] RegRadius = 2'd1;
  localparam logic [1:0] RegDuty   = 2'd2;

  // One divider pipeline stage, three wheels in parallel
  typedef struct packed {
    logic [MagW-1:0]           den;
    logic [2:0][NumW-1:0]      rem;
    logic [2:0][QW-1:0]        quo;
    logic [2:0]                fwd;
  } div_stage_t;

endpackage
`default_nettype wire

// ----- src/omni3_if.sv -----
// Interfaces: chassis command channel and wheel result channel.
`default_nettype none
interface omni3_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] turn_rate;
  modport source (output valid, vel_x, vel_y, turn_rate, input ready);
  modport sink   (input valid, vel_x, vel_y, turn_rate, output ready);
endinterface

interface omni3_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_a;
  logic [7:0] duty_b;
  logic [7:0] duty_c;
  logic       forward_a;
  logic       forward_b;
  logic       forward_c;
  modport source (output valid, duty_a, duty_b, duty_c, forward_a, forward_b, forward_c,
                  input ready);
  modport sink   (input valid, duty_a, duty_b, duty_c, forward_a, forward_b, forward_c,
                  output ready);
endinterface
`default_nettype wire

// ----- src/omni3_wheel_drive_mixer_core.sv -----
// Top level: pipelined three-wheel omni inverse kinematics with normalization.
//
//  channel | dir | handshake      | payload
//  cmd_i   | in  | valid/ready    | vel_x, vel_y, turn_rate (signed Q7.8)
//  res_o   | out | valid/ready    | duty_a..c, forward_a..c
//  apb     | in  | psel/penable   | length, radius, duty limit
//
// One item enters per cycle unless res_o back-pressure stalls the pipe. Stages in order:
// product stage, sum stage, normalizer stage, 16 restoring divider steps (one quotient bit each), duty stage.
// Each stage holds its item when the next stage is full and stalled, so bubbles
// collapse and nothing is lost or repeated. Reset clears valid bits and restores
// registers to L=1.0, R=1.0, limit=255.
`default_nettype none
module omni3_wheel_drive_mixer_core
  import omni3_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  omni3_cmd_if.sink   cmd_i,
  omni3_res_if.source res_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------- configuration registers ----------------
  logic [15:0] len_q, rad_q;
  logic [7:0]  lim_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 16'd256;
      rad_q <= 16'd256;
      lim_q <= 8'd255;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegLength: len_q <= pwdata[15:0];
        RegRadius: rad_q <= pwdata[15:0];
        RegDuty:   lim_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegLength: prdata = {16'd0, len_q};
      RegRadius: prdata = {16'd0, rad_q};
      RegDuty:   prdata = {24'd0, lim_q};
      default:   prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline flow control ----------------
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;

  // a stage loads when it is empty or its item moves on
  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || res_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign cmd_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= cmd_i.valid;
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---------------- stage 1: products ----------------
  logic signed [32:0] turn_prod_q;  // L * turn
  logic signed [33:0] cos_prod_q;   // 0.866 * vx (Q16)
  logic signed [15:0] vy1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      turn_prod_q <= 33'($signed({1'b0, len_q})) * 33'(cmd_i.turn_rate);
      cos_prod_q  <= 34'($signed(Cos30Q16)) * 34'(cmd_i.vel_x);
      vy1_q       <= cmd_i.vel_y;
    end
  end

  // ---------------- stage 2: numerators, magnitudes ----------------
  logic signed [NumW-1:0] t_ext, c_ext, vy16, vy15;
  logic signed [NumW-1:0] num [3];
  logic [2:0][MagW-1:0]   mag_q;
  logic [2:0]             fwd2_q;

  always_comb begin
    t_ext  = NumW'(turn_prod_q) <<< 8;
    c_ext  = NumW'(cos_prod_q);
    vy16   = NumW'(vy1_q) <<< 16;
    vy15   = NumW'(vy1_q) <<< 15;
    num[0] = vy16 + t_ext;
    num[1] = t_ext - c_ext - vy15;
    num[2] = t_ext + c_ext - vy15;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i]  <= num[i][NumW-1] ? MagW'(-num[i]) : MagW'(num[i]);
        fwd2_q[i] <= !num[i][NumW-1];
      end
    end
  end

  // ---------------- stage 3: normalizer ----------------
  logic [MagW-1:0] peak01, peak, den_base;
  div_stage_t      div_q [DivSteps+1];

  always_comb begin
    peak01   = (mag_q[1] > mag_q[0]) ? mag_q[1] : mag_q[0];
    peak     = (mag_q[2] > peak01) ? mag_q[2] : peak01;
    // zero radius behaves as the smallest nonzero radius (one LSB)
    den_base = {10'd0, ((rad_q == 16'd0) ? 16'd1 : rad_q), 16'd0};
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      div_q[0].den <= (peak > den_base) ? peak : den_base;
      for (int i = 0; i < 3; i++) begin
        div_q[0].rem[i] <= {1'b0, mag_q[i]};
        div_q[0].quo[i] <= '0;
      end
      div_q[0].fwd <= fwd2_q;
    end
  end

  // ---------------- divider steps: one quotient bit each ----------------
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    div_stage_t nxt;
    always_comb begin
      logic [NumW-1:0] sh;
      nxt = div_q[k];
      for (int i = 0; i < 3; i++) begin
        // first step compares unshifted: dividend already below 2x divisor
        sh = (k == 0) ? div_q[k].rem[i] : (div_q[k].rem[i] << 1);
        if (sh >= {1'b0, div_q[k].den}) begin
          nxt.rem[i] = sh - {1'b0, div_q[k].den};
          nxt.quo[i] = {div_q[k].quo[i][QW-2:0], 1'b1};
        end else begin
          nxt.rem[i] = sh;
          nxt.quo[i] = {div_q[k].quo[i][QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv[3+k]) div_q[k+1] <= nxt;
    end
  end

  // ---------------- duty stage ----------------
  logic [2:0][QW+7:0] prod;
  logic [2:0][7:0]    duty_q;
  logic [2:0]         fwd_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = (QW+8)'(div_q[DivSteps].quo[i]) * (QW+8)'(lim_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NumStages-1]) begin
      for (int i = 0; i < 3; i++) duty_q[i] <= prod[i][22:15];
      fwd_q <= div_q[DivSteps].fwd;
    end
  end

  assign res_o.valid     = vld_q[NumStages-1];
  assign res_o.duty_a    = duty_q[0];
  assign res_o.duty_b    = duty_q[1];
  assign res_o.duty_c    = duty_q[2];
  assign res_o.forward_a = fwd_q[0];
  assign res_o.forward_b = fwd_q[1];
  assign res_o.forward_c = fwd_q[2];

  // ---------------- assertions ----------------
  // an empty output stage lets the whole pipe move
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.valid |-> cmd_i.ready) else $error("input stalled with empty output");

  // normalized magnitude never exceeds 1.0
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStages-2] |-> (div_q[DivSteps].quo[0] <= 16'd32768 &&
                           div_q[DivSteps].quo[1] <= 16'd32768 &&
                           div_q[DivSteps].quo[2] <= 16'd32768))
    else $error("normalized speed above one");

  // normalizer covers every magnitude
  a_den_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (div_q[0].den >= div_q[0].rem[0][MagW-1:0] &&
                  div_q[0].den >= div_q[0].rem[1][MagW-1:0] &&
                  div_q[0].den >= div_q[0].rem[2][MagW-1:0]))
    else $error("normalizer below a wheel magnitude");

endmodule
`default_nettype wire
